>>> src/a2i_pkg.sv
// a2i_pkg: shared types, character codes and helpers for the ascii to integer parser
// no dependencies; used by the channel interfaces, a2i_mac and the core top level

package a2i_pkg;

   // fixed field widths of the request, response and register port
   localparam int CH_BITS        = 8;
   localparam int VALUE_BITS     = 64;
   localparam int COUNT_BITS     = 16;
   localparam int STATUS_BITS    = 2;
   localparam int BASE_BITS      = 6;
   localparam int DIGIT_BITS     = 6;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 6;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_RADIX    = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_UNSIGNED = 1'd1;

   // response status codes
   localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_INVALID = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_RANGE   = 2'd2;

   // character codes
   localparam logic [CH_BITS-1:0] CH_NUL     = 8'h00;
   localparam logic [CH_BITS-1:0] CH_TAB     = 8'h09;
   localparam logic [CH_BITS-1:0] CH_CR      = 8'h0D;
   localparam logic [CH_BITS-1:0] CH_SPACE   = 8'h20;
   localparam logic [CH_BITS-1:0] CH_PLUS    = 8'h2B;
   localparam logic [CH_BITS-1:0] CH_MINUS   = 8'h2D;
   localparam logic [CH_BITS-1:0] CH_ZERO    = 8'h30;
   localparam logic [CH_BITS-1:0] CH_NINE    = 8'h39;
   localparam logic [CH_BITS-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CH_BITS-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [CH_BITS-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CH_BITS-1:0] CH_LOWER_X = 8'h78;
   localparam logic [CH_BITS-1:0] CH_LOWER_Z = 8'h7A;
   localparam logic [CH_BITS-1:0] CASE_BIT   = 8'h20;

   // base codes
   localparam logic [BASE_BITS-1:0] BASE_AUTO = 6'd0;
   localparam logic [BASE_BITS-1:0] BASE_MIN  = 6'd2;
   localparam logic [BASE_BITS-1:0] BASE_8    = 6'd8;
   localparam logic [BASE_BITS-1:0] BASE_10   = 6'd10;
   localparam logic [BASE_BITS-1:0] BASE_16   = 6'd16;
   localparam logic [BASE_BITS-1:0] BASE_MAX  = 6'd36;

   // digit code for a character that is no digit in any base
   localparam logic [DIGIT_BITS-1:0] DIGIT_NONE  = 6'd63;
   localparam logic [DIGIT_BITS-1:0] DIGIT_ALPHA = 6'd10;

   // parse phase, one-hot
   typedef enum logic [5:0] {
      PH_SKIP   = 6'b000001,
      PH_START  = 6'b000010,
      PH_ZERO   = 6'b000100,
      PH_XSEEN  = 6'b001000,
      PH_DIGITS = 6'b010000,
      PH_DONE   = 6'b100000
   } phase_type;

   // digit value of a character: 0-9, then letters for 10..35
   function automatic logic [DIGIT_BITS-1:0] digit_value(input logic [CH_BITS-1:0] c);
      logic [DIGIT_BITS-1:0] d;
      d = DIGIT_NONE;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         d = DIGIT_BITS'(c - CH_ZERO);
      end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
         d = DIGIT_BITS'(c - CH_LOWER_A) + DIGIT_ALPHA;
      end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
         d = DIGIT_BITS'(c - CH_UPPER_A) + DIGIT_ALPHA;
      end
      return d;
   endfunction

endpackage

>>> src/a2i_if.sv
// a2i_req_if / a2i_rsp_if: valid-ready channels for character requests and parse results
// depends on a2i_pkg for the payload widths

interface a2i_req_if import a2i_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CH_BITS-1:0] ch;

   modport source (output valid, output ch, input ready);
   modport sink   (input valid, input ch, output ready);
endinterface

interface a2i_rsp_if import a2i_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [VALUE_BITS-1:0]  value;
   logic [COUNT_BITS-1:0]  consumed;
   logic [STATUS_BITS-1:0] status;

   modport source (output valid, output value, output consumed, output status, input ready);
   modport sink   (input valid, input value, input consumed, input status, output ready);
endinterface

>>> src/a2i_mac.sv
// a2i_mac: accumulator multiply-add by the base with the range check on the wide product
// depends on a2i_pkg for the base and digit widths

module a2i_mac import a2i_pkg::*; #(
   parameter int WORD_BITS = 64
) (
   input  logic [WORD_BITS-1:0]  acc,
   input  logic [BASE_BITS-1:0]  base,
   input  logic [DIGIT_BITS-1:0] digit,
   input  logic [WORD_BITS-1:0]  limit,
   output logic [WORD_BITS-1:0]  next_acc,
   output logic                  too_big
);

   localparam int MUL_BITS  = WORD_BITS + BASE_BITS;
   localparam int PROD_BITS = MUL_BITS + 1;

   logic [MUL_BITS-1:0]  mul;
   logic [PROD_BITS-1:0] prod;

   // acc * base + digit, kept full width so nothing wraps
   assign mul  = MUL_BITS'(acc) * MUL_BITS'(base);
   assign prod = PROD_BITS'(mul) + PROD_BITS'(digit);

   // a digit overflows exactly when the new value passes the limit
   assign too_big  = prod > PROD_BITS'(limit);
   assign next_acc = prod[WORD_BITS-1:0];

endmodule

>>> src/ascii_to_integer_parser_core.sv
// ascii_to_integer_parser_core: streaming string to integer converter, top level
// depends on a2i_pkg, a2i_req_if / a2i_rsp_if and a2i_mac

// The block takes one character per request and returns one result when the
// terminating NUL arrives: leading white space is skipped, an optional sign is
// read, a 0x prefix counts only when a hex digit follows, and digits of the
// selected base (radix 0 picks 8, 10 or 16) accumulate until the first other
// character. Overflow saturates the value and reports range status; no digits or
// an invalid radix report invalid status with consumed 0. A new character can be
// accepted every clock cycle, also while a result waits on the response side;
// only a NUL waits in the input register until the response register is free,
// and the request channel stalls behind it for that time.
// A character is processed while it sits in the input register; a NUL that
// fires loads the result into the response register at the next edge, and the
// answer to the NUL request is then offered on the response channel from there.
// The per-character path is the accumulator multiply-add by the base and the
// compare against the limit. Registers are to be written by the user only while
// the input register is empty; the block does not enforce it. A change between
// characters applies from the next one, and the base stays fixed once digits start.

module ascii_to_integer_parser_core import a2i_pkg::*; #(
   parameter int WORD_BITS = 64,
   parameter int POS_BITS  = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   a2i_req_if.sink                   req_chan,
   a2i_rsp_if.source                 rsp_chan
);

   // configuration registers
   logic [BASE_BITS-1:0] radix_ff;
   logic                 unsigned_ff;

   // input register
   logic               s1_valid_ff;
   logic [CH_BITS-1:0] s1_ch_ff;

   // parse state
   phase_type            phase_ff, phase_in;
   logic                 neg_ff, neg_in;
   logic                 ovf_ff, ovf_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic                 has_digits_ff, has_digits_in;
   logic [POS_BITS-1:0]  position_ff, position_in;
   logic [POS_BITS-1:0]  end_pos_ff, end_pos_in;
   logic [BASE_BITS-1:0] base_ff, base_in;

   // response register
   logic                   rsp_valid_ff;
   logic [VALUE_BITS-1:0]  rsp_value_ff, rsp_value_in;
   logic [COUNT_BITS-1:0]  rsp_consumed_ff, rsp_consumed_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;

   logic                   fire;
   logic                   is_nul;
   logic                   is_space;
   logic                   start_zero;
   logic                   base_ok;
   logic                   digit_ok;
   logic                   do_digit;
   logic                   has_eff;
   logic                   too_big;
   logic [DIGIT_BITS-1:0]  digit;
   logic [BASE_BITS-1:0]   dec_or_radix;
   logic [BASE_BITS-1:0]   oct_or_hex;
   logic [BASE_BITS-1:0]   step_base;
   logic [POS_BITS-1:0]    pos_inc;
   logic [WORD_BITS-1:0]   word_half;
   logic [WORD_BITS-1:0]   limit;
   logic [WORD_BITS-1:0]   next_acc;
   logic [WORD_BITS-1:0]   result_word;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff    <= BASE_AUTO;
         unsigned_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            REG_RADIX:    radix_ff    <= csr_data[BASE_BITS-1:0];
            REG_UNSIGNED: unsigned_ff <= csr_data[0];
            default:      ;
         endcase
      end
   end

   // a NUL only moves on when the response register is free
   assign is_nul         = s1_ch_ff == CH_NUL;
   assign fire           = s1_valid_ff && (!is_nul || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || fire;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.valid && req_chan.ready) begin
         s1_valid_ff <= 1'b1;
      end else if (fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_ch_ff <= req_chan.ch;
      end
   end

   // character classes and digit value
   assign is_space   = (s1_ch_ff >= CH_TAB && s1_ch_ff <= CH_CR) || s1_ch_ff == CH_SPACE;
   assign digit      = digit_value(s1_ch_ff);
   assign start_zero = (radix_ff == BASE_AUTO || radix_ff == BASE_16) && s1_ch_ff == CH_ZERO;
   assign pos_inc    = (&position_ff) ? position_ff : position_ff + 1'b1;

   // limit for the current sign and mode
   assign word_half = {1'b0, {(WORD_BITS-1){1'b1}}};
   assign limit     = unsigned_ff ? {WORD_BITS{1'b1}} :
                      (neg_ff ? word_half + 1'b1 : word_half);

   // base that a digit in this phase is taken in
   assign dec_or_radix = (radix_ff == BASE_AUTO) ? BASE_10 : radix_ff;
   assign oct_or_hex   = (radix_ff == BASE_AUTO) ? BASE_8 : BASE_16;

   always_comb begin
      case (phase_ff)
         PH_SKIP:  step_base = dec_or_radix;
         PH_START: step_base = dec_or_radix;
         PH_ZERO:  step_base = oct_or_hex;
         PH_XSEEN: step_base = BASE_16;
         default:  step_base = base_ff;
      endcase
   end

   assign base_ok  = step_base >= BASE_MIN && step_base <= BASE_MAX;
   assign digit_ok = base_ok && (digit < step_base);

   a2i_mac #(
      .WORD_BITS (WORD_BITS)
   ) u_mac (
      .acc      (acc_ff),
      .base     (step_base),
      .digit    (digit),
      .limit    (limit),
      .next_acc (next_acc),
      .too_big  (too_big)
   );

   // parse state next value
   always_comb begin
      phase_in      = phase_ff;
      neg_in        = neg_ff;
      ovf_in        = ovf_ff;
      acc_in        = acc_ff;
      has_digits_in = has_digits_ff;
      position_in   = position_ff;
      end_pos_in    = end_pos_ff;
      base_in       = base_ff;
      do_digit      = 1'b0;
      if (fire) begin
         if (is_nul) begin
            phase_in      = PH_SKIP;
            neg_in        = 1'b0;
            ovf_in        = 1'b0;
            acc_in        = '0;
            has_digits_in = 1'b0;
            position_in   = '0;
            end_pos_in    = '0;
            base_in       = BASE_AUTO;
         end else begin
            position_in = pos_inc;
            case (phase_ff)
               PH_SKIP: begin
                  if (is_space) begin
                     phase_in = PH_SKIP;
                  end else if (s1_ch_ff == CH_MINUS) begin
                     neg_in   = 1'b1;
                     phase_in = PH_START;
                  end else if (s1_ch_ff == CH_PLUS) begin
                     phase_in = PH_START;
                  end else if (start_zero) begin
                     base_in    = radix_ff;
                     end_pos_in = pos_inc;
                     phase_in   = PH_ZERO;
                  end else begin
                     base_in  = step_base;
                     do_digit = 1'b1;
                  end
               end
               PH_START: begin
                  if (start_zero) begin
                     base_in    = radix_ff;
                     end_pos_in = pos_inc;
                     phase_in   = PH_ZERO;
                  end else begin
                     base_in  = step_base;
                     do_digit = 1'b1;
                  end
               end
               PH_ZERO: begin
                  if ((s1_ch_ff | CASE_BIT) == CH_LOWER_X) begin
                     phase_in = PH_XSEEN;
                  end else begin
                     base_in       = oct_or_hex;
                     has_digits_in = 1'b1;
                     do_digit      = 1'b1;
                  end
               end
               PH_XSEEN: begin
                  if (digit < BASE_16) begin
                     base_in  = BASE_16;
                     do_digit = 1'b1;
                  end else begin
                     // lone zero before x: the zero is the number
                     base_in       = oct_or_hex;
                     has_digits_in = 1'b1;
                     phase_in      = PH_DONE;
                  end
               end
               PH_DIGITS: begin
                  do_digit = 1'b1;
               end
               default: begin
                  phase_in = PH_DONE;
               end
            endcase

            // digit accumulation, frozen once overflowed
            if (do_digit) begin
               if (digit_ok) begin
                  ovf_in = ovf_ff || too_big;
                  if (!(ovf_ff || too_big)) begin
                     acc_in = next_acc;
                  end
                  has_digits_in = 1'b1;
                  end_pos_in    = pos_inc;
                  phase_in      = PH_DIGITS;
               end else begin
                  phase_in = PH_DONE;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SKIP;
         neg_ff        <= 1'b0;
         ovf_ff        <= 1'b0;
         acc_ff        <= '0;
         has_digits_ff <= 1'b0;
         position_ff   <= '0;
         end_pos_ff    <= '0;
         base_ff       <= BASE_AUTO;
      end else begin
         phase_ff      <= phase_in;
         neg_ff        <= neg_in;
         ovf_ff        <= ovf_in;
         acc_ff        <= acc_in;
         has_digits_ff <= has_digits_in;
         position_ff   <= position_in;
         end_pos_ff    <= end_pos_in;
         base_ff       <= base_in;
      end
   end

   // result at the NUL
   assign has_eff = has_digits_ff || phase_ff == PH_ZERO || phase_ff == PH_XSEEN;

   always_comb begin
      if (ovf_ff) begin
         result_word     = limit;
         rsp_status_in   = ST_RANGE;
         rsp_consumed_in = COUNT_BITS'(end_pos_ff);
      end else if (!has_eff) begin
         result_word     = '0;
         rsp_status_in   = ST_INVALID;
         rsp_consumed_in = '0;
      end else begin
         result_word     = neg_ff ? {WORD_BITS{1'b0}} - acc_ff : acc_ff;
         rsp_status_in   = ST_OK;
         rsp_consumed_in = COUNT_BITS'(end_pos_ff);
      end
      rsp_value_in = VALUE_BITS'(result_word);
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire && is_nul) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && is_nul) begin
         rsp_value_ff    <= rsp_value_in;
         rsp_consumed_ff <= rsp_consumed_in;
         rsp_status_ff   <= rsp_status_in;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.value    = rsp_value_ff;
   assign rsp_chan.consumed = rsp_consumed_ff;
   assign rsp_chan.status   = rsp_status_ff;

   // checks
   a_rsp_from_nul : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fire && is_nul))
      else $error("response raised without a processed NUL");

   a_nul_clears : assert property (@(posedge clock) disable iff (reset)
      (fire && is_nul) |=> (phase_ff == PH_SKIP && position_ff == '0 && !ovf_ff))
      else $error("parse state not cleared after NUL");

   a_ovf_has_digits : assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (has_digits_ff && phase_ff != PH_SKIP && phase_ff != PH_START))
      else $error("overflow flagged without digits");

   a_end_le_pos : assert property (@(posedge clock) disable iff (reset)
      end_pos_ff <= position_ff)
      else $error("end position beyond current position");

endmodule
